>>> rtl/tcf_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the tilt filter.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package tcf_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 24;
   localparam int RATE_W   = 23;
   localparam int ANGLE_W  = 16;

   // Build-time defaults
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 2;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ITER_W           = 5;

   // Register reset values and register indexes
   localparam logic [15:0] BLEND_RESET = 16'd64225;
   localparam logic [23:0] GAIN_RESET  = 24'd128070;
   localparam logic        REG_BLEND   = 1'b0;
   localparam logic        REG_GAIN    = 1'b1;

   // Angle constants in 1/32768 and 1/128 degree
   localparam logic signed [24:0] QUARTER_TURN = 25'sd2949120;
   localparam logic signed [16:0] HALF_TURN    = 17'sd23040;

   // One word waiting between the front end and the back end
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic        [SAMPLE_W-1:0] step_time;
      logic signed [RATE_W-1:0]   rate;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd1474560;
         5'd1:  v = 22'd870484;
         5'd2:  v = 22'd459940;
         5'd3:  v = 22'd233473;
         5'd4:  v = 22'd117189;
         5'd5:  v = 22'd58652;
         5'd6:  v = 22'd29333;
         5'd7:  v = 22'd14667;
         5'd8:  v = 22'd7334;
         5'd9:  v = 22'd3667;
         5'd10: v = 22'd1833;
         5'd11: v = 22'd917;
         5'd12: v = 22'd458;
         5'd13: v = 22'd229;
         5'd14: v = 22'd115;
         5'd15: v = 22'd57;
         5'd16: v = 22'd29;
         5'd17: v = 22'd14;
         5'd18: v = 22'd7;
         5'd19: v = 22'd4;
         5'd20: v = 22'd2;
         5'd21: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tcf_front.sv
// Front end: accepts a request word, scales the gyro reading into a rate.
// Depends on tcf_pkg; feeds tcf_queue.
`default_nettype none
module tcf_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_accel_x,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_accel_z,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_gyro_y,
   input  wire logic        [tcf_pkg::SAMPLE_W-1:0] req_step_time,
   input  wire logic        [tcf_pkg::GAIN_W-1:0]   gyro_gain,
   input  wire tcf_pkg::queue_status_type           q_status,
   output logic                                     push,
   output tcf_pkg::entry_type                       push_entry
);

   logic                 valid_ff;
   logic signed [15:0]   ax_ff;
   logic signed [15:0]   az_ff;
   logic        [15:0]   dt_ff;
   logic signed [41:0]   prod_ff;
   logic signed [16:0]   neg_gyro;
   logic signed [24:0]   gain_s;
   logic signed [41:0]   rounded;
   logic signed [24:0]   rate_wide;
   logic signed [22:0]   rate_sat;
   logic                 accept;

   // The stage is free when empty or when its word moves on this cycle.
   assign push      = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;

   assign neg_gyro = -(17'(req_gyro_y));
   assign gain_s   = signed'({1'b0, gyro_gain});

   // Product register, one multiply per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (push) begin
         valid_ff <= 1'b0;
      end
      if (accept) begin
         ax_ff   <= req_accel_x;
         az_ff   <= req_accel_z;
         dt_ff   <= req_step_time;
         prod_ff <= neg_gyro * gain_s;
      end
   end

   // Round half up at 2^-17, then saturate to the rate range.
   assign rounded   = prod_ff + 42'sd65536;
   assign rate_wide = rounded[41:17];
   always_comb begin
      if (rate_wide > 25'sd4194303) begin
         rate_sat = 23'sd4194303;
      end else if (rate_wide < -25'sd4194304) begin
         rate_sat = -23'sd4194304;
      end else begin
         rate_sat = rate_wide[22:0];
      end
   end

   assign push_entry.accel_x   = ax_ff;
   assign push_entry.accel_z   = az_ff;
   assign push_entry.step_time = dt_ff;
   assign push_entry.rate      = rate_sat;

endmodule
`default_nettype wire

>>> rtl/tcf_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Depends on tcf_pkg; depth must be a power of two.
`default_nettype none
module tcf_queue #(
   parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire tcf_pkg::entry_type       push_entry,
   input  wire logic                     pop,
   output tcf_pkg::entry_type            head,
   output tcf_pkg::queue_status_type     status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tcf_pkg::entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tcf_back.sv
// Back end: CORDIC atan2 of the accelerometer, blend and the result register.
// Depends on tcf_pkg; takes words from tcf_queue.
`default_nettype none
module tcf_back #(
   parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tcf_pkg::entry_type                 head,
   input  wire tcf_pkg::queue_status_type          q_status,
   output logic                                    pop,
   input  wire logic [15:0]                        blend_weight,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [tcf_pkg::ANGLE_W-1:0]      rsp_tilt_angle,
   output logic signed [tcf_pkg::RATE_W-1:0]       rsp_rate,
   output logic signed [tcf_pkg::ANGLE_W-1:0]      rsp_accel_tilt
);

   localparam logic signed [20:0] MICRO   = 21'sd1000000;
   localparam logic signed [57:0] BIAS    = 58'sd32768000000;
   // Any magnitude at or above this saturates the angle in both directions.
   localparam logic [41:0]        MAG_CLIP = 42'd32769000000;
   // One million is 64 * 15625; this is 2^42 / 15625 rounded up.
   localparam logic [28:0]        RECIP_15625 = 29'd281474977;
   localparam int                 ITER_LIM_W = tcf_pkg::ITER_W;
   localparam logic [ITER_LIM_W-1:0] LAST_ITER = ITER_LIM_W'(CORDIC_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CORDIC, ST_ANGLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_DIV, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [4:0]           iter_ff;
   logic signed [35:0]   x_ff;
   logic signed [35:0]   y_ff;
   logic signed [24:0]   z_ff;
   logic signed [15:0]   acc_ff;
   logic signed [15:0]   fused_ff;
   logic signed [22:0]   rate_ff;
   logic [15:0]          dt_ff;
   logic signed [39:0]   p_gd_ff;
   logic signed [36:0]   p_fa_ff;
   logic signed [35:0]   p_acc_ff;
   logic signed [40:0]   g_ff;
   logic signed [57:0]   pw_ff;
   logic signed [53:0]   pa_ff;
   logic                 neg_ff;
   logic [28:0]          scaled_ff;
   logic [57:0]          recip_ff;
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_tilt_ff;
   logic signed [22:0]   rsp_rate_ff;
   logic signed [15:0]   rsp_acc_ff;

   // Combinational helpers
   logic signed [16:0]   ax17;
   logic signed [16:0]   az17;
   logic signed [16:0]   pre_x;
   logic signed [16:0]   pre_y;
   logic signed [24:0]   pre_z;
   logic signed [35:0]   dx;
   logic signed [35:0]   dy;
   logic signed [24:0]   atan_s;
   logic signed [24:0]   z_round;
   logic signed [16:0]   z_deg;
   logic signed [15:0]   angle_sat;
   logic signed [57:0]   biased;
   logic signed [41:0]   numer;
   logic [41:0]          magnitude;
   logic [41:0]          mag_clip;
   logic [15:0]          quo;
   logic signed [20:0]   quo_signed;
   logic signed [15:0]   blend_sat;
   logic signed [16:0]   dt_s;
   logic signed [16:0]   w_s;
   logic signed [17:0]   wc_s;
   logic                 out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tilt_angle = rsp_tilt_ff;
   assign rsp_rate       = rsp_rate_ff;
   assign rsp_accel_tilt = rsp_acc_ff;

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Quadrant pre-rotation: a negative Z turns the vector by a quarter turn.
   assign ax17 = 17'(head.accel_x);
   assign az17 = 17'(head.accel_z);
   always_comb begin
      if (az17 < 0) begin
         if (ax17 >= 0) begin
            pre_x = ax17;
            pre_y = -az17;
            pre_z = tcf_pkg::QUARTER_TURN;
         end else begin
            pre_x = -ax17;
            pre_y = az17;
            pre_z = -tcf_pkg::QUARTER_TURN;
         end
      end else begin
         pre_x = az17;
         pre_y = ax17;
         pre_z = '0;
      end
   end

   // One CORDIC micro-rotation per cycle.
   assign dx     = y_ff >>> iter_ff;
   assign dy     = x_ff >>> iter_ff;
   assign atan_s = signed'({3'b000, tcf_pkg::atan_entry(iter_ff)});

   // Round the angle to 1/128 degree and clamp to a half turn.
   assign z_round = z_ff + 25'sd128;
   assign z_deg   = z_round[24:8];
   always_comb begin
      if (z_deg > tcf_pkg::HALF_TURN) begin
         angle_sat = 16'(tcf_pkg::HALF_TURN);
      end else if (z_deg < -tcf_pkg::HALF_TURN) begin
         angle_sat = -16'(tcf_pkg::HALF_TURN);
      end else begin
         angle_sat = z_deg[15:0];
      end
   end

   // Blend operands
   assign dt_s = signed'({1'b0, dt_ff});
   assign w_s  = signed'({1'b0, blend_weight});
   assign wc_s = 18'sd65536 - signed'({2'b00, blend_weight});

   // Round half up at 2^-16, then prepare a floor division by one million.
   assign biased    = pw_ff + pa_ff + BIAS;
   assign numer     = biased[57:16];
   assign magnitude = numer[41] ? 42'(-numer + 42'sd999999) : 42'(numer);
   assign mag_clip  = (magnitude > MAG_CLIP) ? MAG_CLIP : magnitude;

   // The reciprocal product is exact for every clipped magnitude.
   assign quo        = recip_ff[57:42];
   assign quo_signed = neg_ff ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
   always_comb begin
      if (quo_signed > 21'sd32767) begin
         blend_sat = 16'sh7fff;
      end else if (quo_signed < -21'sd32768) begin
         blend_sat = -16'sh8000;
      end else begin
         blend_sat = quo_signed[15:0];
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fused_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  rate_ff <= head.rate;
                  dt_ff   <= head.step_time;
                  iter_ff <= '0;
                  x_ff    <= {{3{pre_x[16]}}, pre_x, 16'd0};
                  y_ff    <= {{3{pre_y[16]}}, pre_y, 16'd0};
                  z_ff    <= pre_z;
                  if (head.accel_x == '0) begin
                     acc_ff   <= (head.accel_z < 0) ? 16'(tcf_pkg::HALF_TURN) : '0;
                     state_ff <= ST_MUL1;
                  end else begin
                     state_ff <= ST_CORDIC;
                  end
               end
            end
            ST_CORDIC: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_s;
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_s;
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == LAST_ITER) begin
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE: begin
               acc_ff   <= angle_sat;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               p_gd_ff  <= rate_ff * dt_s;
               p_fa_ff  <= fused_ff * MICRO;
               p_acc_ff <= acc_ff * MICRO;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               g_ff     <= p_fa_ff + p_gd_ff;
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               pw_ff    <= w_s * g_ff;
               pa_ff    <= wc_s * p_acc_ff;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               // Dropping the low six bits divides by 64 exactly in floor terms.
               neg_ff    <= numer[41];
               scaled_ff <= 29'(mag_clip >> 6);
               state_ff  <= ST_DIV;
            end
            ST_DIV: begin
               // Division by 15625 as a multiply by its scaled reciprocal.
               recip_ff <= 58'(scaled_ff) * 58'(RECIP_15625);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  fused_ff     <= blend_sat;
                  rsp_tilt_ff  <= blend_sat;
                  rsp_rate_ff  <= rate_ff;
                  rsp_acc_ff   <= acc_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/tilt_complementary_filter.sv
// Top level of the accelerometer/gyro complementary tilt filter.
// Depends on tcf_pkg, tcf_front, tcf_queue and tcf_back.
//
//   channel   direction  handshake          word
//   req       in         req_valid/stall    accel_x, accel_z, gyro_y, step_time
//   rsp       out        rsp_valid/stall    tilt_angle, rate, accel_tilt
//   csr       in/out     psel/penable       blend_weight (0x0), gyro_gain (0x4)
//
// A word passes the front-end product register and the queue; the back end then
// runs the CORDIC rotations, rounds the angle, forms the blend products, sums and
// divides by a reciprocal multiply and loads the result register. A word with zero
// X skips the rotations and the angle step. The back end handles one word at a time.
// Reset is synchronous; it clears the kept angle and loads the default weights.
// A stalled result holds in the output register while the front end and queue
// keep taking words until the queue is full.
`default_nettype none
module tilt_complementary_filter #(
   parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH  = tcf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_accel_x,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_accel_z,
   input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] req_gyro_y,
   input  wire logic        [tcf_pkg::SAMPLE_W-1:0] req_step_time,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [tcf_pkg::ANGLE_W-1:0]       rsp_tilt_angle,
   output logic signed [tcf_pkg::RATE_W-1:0]        rsp_rate,
   output logic signed [tcf_pkg::ANGLE_W-1:0]       rsp_accel_tilt,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [2:0]                          paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   logic [15:0]                  blend_ff;
   logic [23:0]                  gain_ff;
   logic                         push;
   logic                         pop;
   tcf_pkg::entry_type           push_entry;
   tcf_pkg::entry_type           head;
   tcf_pkg::queue_status_type    q_status;

   // Register port: writes land on the access cycle, reads are immediate.
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= tcf_pkg::BLEND_RESET;
         gain_ff  <= tcf_pkg::GAIN_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            tcf_pkg::REG_BLEND: blend_ff <= pwdata[15:0];
            tcf_pkg::REG_GAIN:  gain_ff  <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         tcf_pkg::REG_BLEND: prdata = {16'd0, blend_ff};
         tcf_pkg::REG_GAIN:  prdata = {8'd0, gain_ff};
         default:            prdata = '0;
      endcase
   end

   tcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_accel_x   (req_accel_x),
      .req_accel_z   (req_accel_z),
      .req_gyro_y    (req_gyro_y),
      .req_step_time (req_step_time),
      .gyro_gain     (gain_ff),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   tcf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   tcf_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .blend_weight   (blend_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tilt_angle (rsp_tilt_angle),
      .rsp_rate       (rsp_rate),
      .rsp_accel_tilt (rsp_accel_tilt)
   );

   // The queue can never look empty and full at once.
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue reports empty and full together");

   // The back end only takes a word that is present.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   // The accelerometer angle stays within a half turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accel_tilt <= 16'sd23040 && rsp_accel_tilt >= -16'sd23040))
      else $error("accelerometer angle out of range");

endmodule
`default_nettype wire
